@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL modules.
// Each macro expects clk and rst_n to be visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Expression must never be true out of reset.
`define ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

@@ rtl/cpcr_pkg.sv @@
package cpcr_pkg;

    localparam int POS_W     = 24;
    localparam int CD_W      = 20;
    localparam int IM_W      = 16;
    localparam int FRAC_W    = 16;
    localparam int CFG_AW    = 3;
    localparam int CFG_DW    = 20;

    localparam logic [CD_W-1:0]   CD_RESET   = 20'd0;
    localparam logic [IM_W-1:0]   IMA_RESET  = 16'd4096;
    localparam logic [IM_W-1:0]   IMB_RESET  = 16'd4096;
    localparam logic [FRAC_W-1:0] REST_RESET = 16'd32768;
    localparam logic [FRAC_W-1:0] CORR_RESET = 16'd26214;

    typedef enum logic [CFG_AW-1:0] {
        CFG_CONTACT_DISTANCE    = 3'd0,
        CFG_INV_MASS_FIRST      = 3'd1,
        CFG_INV_MASS_SECOND     = 3'd2,
        CFG_RESTITUTION         = 3'd3,
        CFG_CORRECTION_FRACTION = 3'd4
    } cfg_idx_t;

endpackage

@@ rtl/cpcr_div.sv @@
`include "assert_macros.svh"

// Pipelined restoring divider: one quotient bit per stage, LANES numerators
// share one divisor. The caller guarantees num < den * 2**QW.
module cpcr_div #(
    parameter int LANES = 1,
    parameter int NW    = 8,
    parameter int DW    = 8,
    parameter int QW    = 8,
    parameter int SW    = 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [LANES-1:0][NW-1:0]    num,
    input  logic [DW-1:0]               den,
    input  logic [SW-1:0]               in_side,
    output logic                        out_valid,
    output logic [LANES-1:0][QW-1:0]    quot,
    output logic [SW-1:0]               out_side
);

    localparam int RW = DW + QW;

    logic                       valid_reg [QW];
    logic [LANES-1:0][RW-1:0]   rem_reg   [QW];
    logic [LANES-1:0][QW-1:0]   quot_reg  [QW];
    logic [DW-1:0]              den_reg   [QW];
    logic [SW-1:0]              side_reg  [QW];

    for (genvar st = 0; st < QW; st++)
    begin : g_stage
        localparam int SH = QW - 1 - st;

        logic                       vld_in;
        logic [LANES-1:0][RW-1:0]   rem_in;
        logic [LANES-1:0][QW-1:0]   q_in;
        logic [DW-1:0]              den_in;
        logic [SW-1:0]              side_in;
        logic [RW-1:0]              trial;
        logic [LANES-1:0][RW-1:0]   rem_next;
        logic [LANES-1:0][QW-1:0]   q_next;

        // select stage source
        if (st == 0)
        begin : g_first
            always_comb
            begin
                vld_in  = in_valid;
                den_in  = den;
                side_in = in_side;
                q_in    = '0;
                for (int l = 0; l < LANES; l++)
                begin
                    rem_in[l] = RW'(num[l]);
                end
            end
        end
        else
        begin : g_rest
            assign vld_in  = valid_reg[st-1];
            assign den_in  = den_reg[st-1];
            assign side_in = side_reg[st-1];
            assign q_in    = quot_reg[st-1];
            assign rem_in  = rem_reg[st-1];
        end

        assign trial = RW'(den_in) << SH;

        // try one quotient bit per lane
        for (genvar ln = 0; ln < LANES; ln++)
        begin : g_lane
            always_comb
            begin
                rem_next[ln] = rem_in[ln];
                q_next[ln]   = q_in[ln];
                if (rem_in[ln] >= trial)
                begin
                    rem_next[ln]   = rem_in[ln] - trial;
                    q_next[ln][SH] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[st] <= 1'b0;
            else
                valid_reg[st] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[st]  <= rem_next;
            quot_reg[st] <= q_next;
            den_reg[st]  <= den_in;
            side_reg[st] <= side_in;
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign quot      = quot_reg[QW-1];
    assign out_side  = side_reg[QW-1];

    `ASSERT_IMPLY(a_div_latency, out_valid, $past(in_valid, QW), "divider result without request")

endmodule

@@ rtl/cpcr_sqrt.sv @@
`include "assert_macros.svh"

// Pipelined integer square root, floor(sqrt(x)): one root bit per stage.
module cpcr_sqrt #(
    parameter int XW = 8,
    parameter int SW = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [XW-1:0]       x,
    input  logic [SW-1:0]       in_side,
    output logic                out_valid,
    output logic [XW/2-1:0]     root,
    output logic [SW-1:0]       out_side
);

    localparam int RW = XW / 2;

    logic               valid_reg [RW];
    logic [XW-1:0]      rem_reg   [RW];
    logic [RW-1:0]      root_reg  [RW];
    logic [SW-1:0]      side_reg  [RW];

    for (genvar st = 0; st < RW; st++)
    begin : g_stage
        localparam int K = RW - 1 - st;

        logic           vld_in;
        logic [XW-1:0]  rem_in;
        logic [RW-1:0]  r_in;
        logic [SW-1:0]  side_in;
        logic [XW-1:0]  delta;
        logic [XW-1:0]  rem_next;
        logic [RW-1:0]  r_next;

        if (st == 0)
        begin : g_first
            assign vld_in  = in_valid;
            assign rem_in  = x;
            assign r_in    = '0;
            assign side_in = in_side;
        end
        else
        begin : g_rest
            assign vld_in  = valid_reg[st-1];
            assign rem_in  = rem_reg[st-1];
            assign r_in    = root_reg[st-1];
            assign side_in = side_reg[st-1];
        end

        // (r + 2^k)^2 - r^2 = r*2^(k+1) + 2^(2k)
        assign delta = (XW'(r_in) << (K + 1)) | (XW'(1) << (2 * K));

        always_comb
        begin
            rem_next = rem_in;
            r_next   = r_in;
            if (rem_in >= delta)
            begin
                rem_next  = rem_in - delta;
                r_next[K] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[st] <= 1'b0;
            else
                valid_reg[st] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[st]  <= rem_next;
            root_reg[st] <= r_next;
            side_reg[st] <= side_in;
        end
    end

    assign out_valid = valid_reg[RW-1];
    assign root      = root_reg[RW-1];
    assign out_side  = side_reg[RW-1];

    `ASSERT_IMPLY(a_sqrt_latency, out_valid, $past(in_valid, RW), "root result without request")

endmodule

@@ rtl/circle_pair_collision_resolver.sv @@
// Path: registers s1-s3, length root, s4-s5, push divider, s6, axis divider, s7-s10,
// norm root, s11, then the impulse dividers with s12-s14; done is registered with the results.
// Throughput: one transaction per cycle; busy is always low, set by the fully
// pipelined square-root and divider stages (one result bit per stage).
// Reset: rst_n asynchronous active low clears all valid bits and loads the
// register defaults; results are never held back since the receiver cannot stall.
`include "assert_macros.svh"

module circle_pair_collision_resolver
    import cpcr_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [CFG_AW-1:0]           cfg_addr,
    input  logic [CFG_DW-1:0]           cfg_wdata,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [POS_W-1:0]     pos_ax,
    input  logic signed [POS_W-1:0]     pos_ay,
    input  logic signed [POS_W-1:0]     vel_ax,
    input  logic signed [POS_W-1:0]     vel_ay,
    input  logic signed [POS_W-1:0]     pos_bx,
    input  logic signed [POS_W-1:0]     pos_by,
    input  logic signed [POS_W-1:0]     vel_bx,
    input  logic signed [POS_W-1:0]     vel_by,
    output logic                        done,
    output logic signed [POS_W-1:0]     new_pos_ax,
    output logic signed [POS_W-1:0]     new_pos_ay,
    output logic signed [POS_W-1:0]     new_vel_ax,
    output logic signed [POS_W-1:0]     new_vel_ay,
    output logic signed [POS_W-1:0]     new_pos_bx,
    output logic signed [POS_W-1:0]     new_pos_by,
    output logic signed [POS_W-1:0]     new_vel_bx,
    output logic signed [POS_W-1:0]     new_vel_by,
    output logic                        in_contact,
    output logic                        impulse_applied
);

    typedef struct packed {
        logic signed [23:0] ax;
        logic signed [23:0] ay;
        logic signed [23:0] vax;
        logic signed [23:0] vay;
        logic signed [23:0] bx;
        logic signed [23:0] by;
        logic signed [23:0] vbx;
        logic signed [23:0] vby;
    } bodies_t;

    typedef struct packed {
        bodies_t            bod;
        logic signed [24:0] dx;
        logic signed [24:0] dy;
        logic               contact;
    } ctx_a_t;

    typedef struct packed {
        ctx_a_t             a;
        logic [19:0]        len;
        logic               push_ok;
    } ctx_b_t;

    typedef struct packed {
        bodies_t            bod;
        logic               contact;
    } ctx_c_t;

    typedef struct packed {
        bodies_t            bod;
        logic               contact;
        logic signed [24:0] nx;
        logic signed [24:0] ny;
        logic signed [50:0] s;
    } ctx_d_t;

    typedef struct packed {
        bodies_t            bod;
        logic               contact;
        logic signed [24:0] nx;
        logic signed [24:0] ny;
        logic [23:0]        len2;
        logic               imp_ok;
    } ctx_e_t;

    // magnitude of a signed difference
    function automatic logic [24:0] mag25(input logic signed [24:0] v);
        mag25 = v[24] ? (~v + 25'd1) : v;
    endfunction

    // add or subtract a magnitude, then saturate to 24 bits
    function automatic logic signed [23:0] move_sat(input logic signed [23:0] p,
                                                   input logic neg,
                                                   input logic [27:0] q);
        logic signed [29:0] ext;
        logic signed [29:0] dq;
        logic signed [29:0] sum;
        ext = 30'(p);
        dq  = $signed({2'b00, q});
        sum = neg ? (ext - dq) : (ext + dq);
        if (sum > 30'sd8388607)
            move_sat = 24'sh7FFFFF;
        else if (sum < -30'sd8388608)
            move_sat = 24'sh800000;
        else
            move_sat = sum[23:0];
    endfunction

    // ---------------- configuration registers ----------------
    logic [CD_W-1:0]    cd_reg;
    logic [IM_W-1:0]    ima_reg;
    logic [IM_W-1:0]    imb_reg;
    logic [FRAC_W-1:0]  rest_reg;
    logic [FRAC_W-1:0]  corr_reg;
    logic [39:0]        cd_sq_reg;
    logic [16:0]        total;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cd_reg    <= CD_RESET;
            ima_reg   <= IMA_RESET;
            imb_reg   <= IMB_RESET;
            rest_reg  <= REST_RESET;
            corr_reg  <= CORR_RESET;
            cd_sq_reg <= '0;
        end
        else
        begin
            cd_sq_reg <= cd_reg * cd_reg;
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_addr))
                    CFG_CONTACT_DISTANCE:    cd_reg   <= cfg_wdata;
                    CFG_INV_MASS_FIRST:      ima_reg  <= cfg_wdata[IM_W-1:0];
                    CFG_INV_MASS_SECOND:     imb_reg  <= cfg_wdata[IM_W-1:0];
                    CFG_RESTITUTION:         rest_reg <= cfg_wdata[FRAC_W-1:0];
                    CFG_CORRECTION_FRACTION: corr_reg <= cfg_wdata[FRAC_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign total = {1'b0, ima_reg} + {1'b0, imb_reg};
    assign busy  = 1'b0;

    // ---------------- stage declarations ----------------
    logic               s1_valid_reg;
    bodies_t            s1_bod_reg;
    logic signed [24:0] s1_dx_reg, s1_dy_reg;

    logic               s2_valid_reg;
    bodies_t            s2_bod_reg;
    logic signed [24:0] s2_dx_reg, s2_dy_reg;
    logic [49:0]        s2_dx2_reg, s2_dy2_reg;

    logic               s3_valid_reg;
    ctx_a_t             s3_ctx_reg;
    logic [39:0]        s3_d2_reg;

    logic               q1_valid;
    logic [19:0]        q1_len;
    ctx_a_t             q1_ctx;

    logic               s4_valid_reg;
    ctx_b_t             s4_ctx_reg;
    logic [35:0]        s4_base_reg;

    logic               s5_valid_reg;
    ctx_b_t             s5_ctx_reg;
    logic [1:0][36:0]   s5_num_reg;

    logic               d1_valid;
    logic [1:0][20:0]   d1_quot;
    ctx_b_t             d1_ctx;

    logic               s6_valid_reg;
    ctx_b_t             s6_ctx_reg;
    logic [3:0][40:0]   s6_prod_reg;

    logic               d2_valid;
    logic [3:0][20:0]   d2_quot;
    ctx_b_t             d2_ctx;

    logic               s7_valid_reg;
    ctx_c_t             s7_ctx_reg;

    logic               s8_valid_reg;
    ctx_c_t             s8_ctx_reg;
    logic signed [24:0] s8_nx_reg, s8_ny_reg, s8_dvx_reg, s8_dvy_reg;

    logic               s9_valid_reg;
    ctx_c_t             s9_ctx_reg;
    logic signed [24:0] s9_nx_reg, s9_ny_reg;
    logic signed [49:0] s9_nx2_reg, s9_ny2_reg, s9_px_reg, s9_py_reg;

    logic               s10_valid_reg;
    ctx_d_t             s10_ctx_reg;
    logic [47:0]        s10_n2_reg;

    logic               r2_valid;
    logic [23:0]        r2_len;
    ctx_d_t             r2_ctx;

    logic               s11_valid_reg;
    ctx_e_t             s11_ctx_reg;
    logic [0:0][49:0]   s11_num_reg;

    logic               d3_valid;
    logic [0:0][25:0]   d3_quot;
    ctx_e_t             d3_ctx;

    logic               s12_valid_reg;
    ctx_e_t             s12_ctx_reg;
    logic [27:0]        s12_g_reg;

    logic               s13_valid_reg;
    ctx_e_t             s13_ctx_reg;
    logic [1:0][43:0]   s13_num_reg;

    logic               d4_valid;
    logic [1:0][27:0]   d4_quot;
    ctx_e_t             d4_ctx;

    logic               s14_valid_reg;
    ctx_e_t             s14_ctx_reg;
    logic [3:0][51:0]   s14_prod_reg;

    logic               d5_valid;
    logic [3:0][27:0]   d5_quot;
    ctx_e_t             d5_ctx;

    logic               done_reg;
    bodies_t            out_bod_reg;
    logic               out_contact_reg;
    logic               out_applied_reg;

    // ---------------- combinational terms ----------------
    logic signed [24:0] in_dx, in_dy;
    logic signed [49:0] sq_dx, sq_dy;
    logic [50:0]        d2_sum;
    logic               contact_now;
    logic               push_ok_now;
    logic [19:0]        overlap;
    logic [35:0]        base_now;
    logic [51:0]        na_full, nb_full;
    logic [24:0]        mdx, mdy;
    logic [19:0]        adx, ady;
    logic [40:0]        p_ax, p_ay, p_bx, p_by;
    bodies_t            pushed;
    logic signed [24:0] nx_now, ny_now, dvx_now, dvy_now;
    logic signed [49:0] sq_nx, sq_ny, dot_x, dot_y;
    logic [47:0]        n2_sum;
    logic signed [50:0] s_sum;
    logic signed [50:0] s_neg;
    logic [16:0]        rest_fac;
    logic [42:0]        g_full;
    logic [43:0]        ga_full, gb_full;
    logic [24:0]        mnx, mny;
    logic [23:0]        anx, any;
    logic [51:0]        p_vax, p_vay, p_vbx, p_vby;
    bodies_t            kicked;

    // center difference and its squares
    assign in_dx = {pos_ax[23], pos_ax} - {pos_bx[23], pos_bx};
    assign in_dy = {pos_ay[23], pos_ay} - {pos_by[23], pos_by};
    assign sq_dx = s1_dx_reg * s1_dx_reg;
    assign sq_dy = s1_dy_reg * s1_dy_reg;

    // contact test against the squared contact distance
    assign d2_sum      = {1'b0, s2_dx2_reg} + {1'b0, s2_dy2_reg};
    assign contact_now = d2_sum <= {11'd0, cd_sq_reg};

    // overlap and push share
    assign push_ok_now = q1_ctx.contact && (q1_len != '0) && (q1_len < cd_reg)
                         && (total != '0);
    assign overlap     = cd_reg - q1_len;
    assign base_now    = overlap * corr_reg;
    assign na_full     = s4_base_reg * ima_reg;
    assign nb_full     = s4_base_reg * imb_reg;

    // per-axis push numerators
    assign mdx  = mag25(d1_ctx.a.dx);
    assign mdy  = mag25(d1_ctx.a.dy);
    assign adx  = mdx[19:0];
    assign ady  = mdy[19:0];
    assign p_ax = adx * d1_quot[0];
    assign p_ay = ady * d1_quot[0];
    assign p_bx = adx * d1_quot[1];
    assign p_by = ady * d1_quot[1];

    // corrected positions, first body along +d, second along -d
    always_comb
    begin
        pushed = d2_ctx.a.bod;
        if (d2_ctx.push_ok)
        begin
            pushed.ax = move_sat(d2_ctx.a.bod.ax, d2_ctx.a.dx[24], {7'd0, d2_quot[0]});
            pushed.ay = move_sat(d2_ctx.a.bod.ay, d2_ctx.a.dy[24], {7'd0, d2_quot[1]});
            pushed.bx = move_sat(d2_ctx.a.bod.bx, !d2_ctx.a.dx[24], {7'd0, d2_quot[2]});
            pushed.by = move_sat(d2_ctx.a.bod.by, !d2_ctx.a.dy[24], {7'd0, d2_quot[3]});
        end
    end

    // corrected normal and relative velocity
    assign nx_now  = {s7_ctx_reg.bod.bx[23], s7_ctx_reg.bod.bx}
                   - {s7_ctx_reg.bod.ax[23], s7_ctx_reg.bod.ax};
    assign ny_now  = {s7_ctx_reg.bod.by[23], s7_ctx_reg.bod.by}
                   - {s7_ctx_reg.bod.ay[23], s7_ctx_reg.bod.ay};
    assign dvx_now = {s7_ctx_reg.bod.vbx[23], s7_ctx_reg.bod.vbx}
                   - {s7_ctx_reg.bod.vax[23], s7_ctx_reg.bod.vax};
    assign dvy_now = {s7_ctx_reg.bod.vby[23], s7_ctx_reg.bod.vby}
                   - {s7_ctx_reg.bod.vay[23], s7_ctx_reg.bod.vay};
    assign sq_nx   = s8_nx_reg * s8_nx_reg;
    assign sq_ny   = s8_ny_reg * s8_ny_reg;
    assign dot_x   = s8_dvx_reg * s8_nx_reg;
    assign dot_y   = s8_dvy_reg * s8_ny_reg;
    assign n2_sum  = s9_nx2_reg[47:0] + s9_ny2_reg[47:0];
    assign s_sum   = s9_px_reg + s9_py_reg;
    assign s_neg   = -r2_ctx.s;

    // impulse magnitude terms
    assign rest_fac = 17'd32768 + {1'b0, rest_reg};
    assign g_full   = d3_quot[0] * rest_fac;
    assign ga_full  = s12_g_reg * ima_reg;
    assign gb_full  = s12_g_reg * imb_reg;
    assign mnx      = mag25(d4_ctx.nx);
    assign mny      = mag25(d4_ctx.ny);
    assign anx      = mnx[23:0];
    assign any      = mny[23:0];
    assign p_vax    = anx * d4_quot[0];
    assign p_vay    = any * d4_quot[0];
    assign p_vbx    = anx * d4_quot[1];
    assign p_vby    = any * d4_quot[1];

    // new velocities, first body against n, second along n
    always_comb
    begin
        kicked = d5_ctx.bod;
        if (d5_ctx.imp_ok)
        begin
            kicked.vax = move_sat(d5_ctx.bod.vax, !d5_ctx.nx[24], d5_quot[0]);
            kicked.vay = move_sat(d5_ctx.bod.vay, !d5_ctx.ny[24], d5_quot[1]);
            kicked.vbx = move_sat(d5_ctx.bod.vbx, d5_ctx.nx[24], d5_quot[2]);
            kicked.vby = move_sat(d5_ctx.bod.vby, d5_ctx.ny[24], d5_quot[3]);
        end
    end

    // ---------------- valid chain ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            s7_valid_reg  <= 1'b0;
            s8_valid_reg  <= 1'b0;
            s9_valid_reg  <= 1'b0;
            s10_valid_reg <= 1'b0;
            s11_valid_reg <= 1'b0;
            s12_valid_reg <= 1'b0;
            s13_valid_reg <= 1'b0;
            s14_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= start && !busy;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= q1_valid;
            s5_valid_reg  <= s4_valid_reg;
            s6_valid_reg  <= d1_valid;
            s7_valid_reg  <= d2_valid;
            s8_valid_reg  <= s7_valid_reg;
            s9_valid_reg  <= s8_valid_reg;
            s10_valid_reg <= s9_valid_reg;
            s11_valid_reg <= r2_valid;
            s12_valid_reg <= d3_valid;
            s13_valid_reg <= s12_valid_reg;
            s14_valid_reg <= d4_valid;
            done_reg      <= d5_valid;
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        // capture transaction
        s1_bod_reg  <= '{pos_ax, pos_ay, vel_ax, vel_ay, pos_bx, pos_by, vel_bx, vel_by};
        s1_dx_reg   <= in_dx;
        s1_dy_reg   <= in_dy;

        s2_bod_reg  <= s1_bod_reg;
        s2_dx_reg   <= s1_dx_reg;
        s2_dy_reg   <= s1_dy_reg;
        s2_dx2_reg  <= sq_dx;
        s2_dy2_reg  <= sq_dy;

        s3_ctx_reg  <= '{s2_bod_reg, s2_dx_reg, s2_dy_reg, contact_now};
        s3_d2_reg   <= d2_sum[39:0];

        s4_ctx_reg  <= '{q1_ctx, q1_len, push_ok_now};
        s4_base_reg <= base_now;

        s5_ctx_reg    <= s4_ctx_reg;
        s5_num_reg[0] <= na_full[51:15];
        s5_num_reg[1] <= nb_full[51:15];

        s6_ctx_reg     <= d1_ctx;
        s6_prod_reg[0] <= p_ax;
        s6_prod_reg[1] <= p_ay;
        s6_prod_reg[2] <= p_bx;
        s6_prod_reg[3] <= p_by;

        s7_ctx_reg  <= '{pushed, d2_ctx.a.contact};

        s8_ctx_reg  <= s7_ctx_reg;
        s8_nx_reg   <= nx_now;
        s8_ny_reg   <= ny_now;
        s8_dvx_reg  <= dvx_now;
        s8_dvy_reg  <= dvy_now;

        s9_ctx_reg  <= s8_ctx_reg;
        s9_nx_reg   <= s8_nx_reg;
        s9_ny_reg   <= s8_ny_reg;
        s9_nx2_reg  <= sq_nx;
        s9_ny2_reg  <= sq_ny;
        s9_px_reg   <= dot_x;
        s9_py_reg   <= dot_y;

        s10_ctx_reg <= '{s9_ctx_reg.bod, s9_ctx_reg.contact, s9_nx_reg, s9_ny_reg, s_sum};
        s10_n2_reg  <= n2_sum;

        // impulse only when approaching along a usable normal
        s11_ctx_reg <= '{r2_ctx.bod, r2_ctx.contact, r2_ctx.nx, r2_ctx.ny, r2_len,
                         r2_ctx.contact && (r2_len != '0) && (total != '0) && r2_ctx.s[50]};
        s11_num_reg[0] <= s_neg[49:0];

        s12_ctx_reg <= d3_ctx;
        s12_g_reg   <= g_full[42:15];

        s13_ctx_reg    <= s12_ctx_reg;
        s13_num_reg[0] <= ga_full;
        s13_num_reg[1] <= gb_full;

        s14_ctx_reg     <= d4_ctx;
        s14_prod_reg[0] <= p_vax;
        s14_prod_reg[1] <= p_vay;
        s14_prod_reg[2] <= p_vbx;
        s14_prod_reg[3] <= p_vby;

        out_bod_reg     <= kicked;
        out_contact_reg <= d5_ctx.contact;
        out_applied_reg <= d5_ctx.imp_ok;
    end

    // ---------------- shared arithmetic units ----------------
    cpcr_sqrt #(.XW(40), .SW($bits(ctx_a_t))) u_len_root (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s3_valid_reg), .x(s3_d2_reg), .in_side(s3_ctx_reg),
        .out_valid(q1_valid), .root(q1_len), .out_side(q1_ctx)
    );

    cpcr_div #(.LANES(2), .NW(37), .DW(17), .QW(21), .SW($bits(ctx_b_t))) u_push_div (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s5_valid_reg), .num(s5_num_reg), .den(total), .in_side(s5_ctx_reg),
        .out_valid(d1_valid), .quot(d1_quot), .out_side(d1_ctx)
    );

    cpcr_div #(.LANES(4), .NW(41), .DW(20), .QW(21), .SW($bits(ctx_b_t))) u_axis_div (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s6_valid_reg), .num(s6_prod_reg), .den(s6_ctx_reg.len),
        .in_side(s6_ctx_reg),
        .out_valid(d2_valid), .quot(d2_quot), .out_side(d2_ctx)
    );

    cpcr_sqrt #(.XW(48), .SW($bits(ctx_d_t))) u_norm_root (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s10_valid_reg), .x(s10_n2_reg), .in_side(s10_ctx_reg),
        .out_valid(r2_valid), .root(r2_len), .out_side(r2_ctx)
    );

    cpcr_div #(.LANES(1), .NW(50), .DW(24), .QW(26), .SW($bits(ctx_e_t))) u_vn_div (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s11_valid_reg), .num(s11_num_reg), .den(s11_ctx_reg.len2),
        .in_side(s11_ctx_reg),
        .out_valid(d3_valid), .quot(d3_quot), .out_side(d3_ctx)
    );

    cpcr_div #(.LANES(2), .NW(44), .DW(17), .QW(28), .SW($bits(ctx_e_t))) u_share_div (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s13_valid_reg), .num(s13_num_reg), .den(total), .in_side(s13_ctx_reg),
        .out_valid(d4_valid), .quot(d4_quot), .out_side(d4_ctx)
    );

    cpcr_div #(.LANES(4), .NW(52), .DW(24), .QW(28), .SW($bits(ctx_e_t))) u_kick_div (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s14_valid_reg), .num(s14_prod_reg), .den(s14_ctx_reg.len2),
        .in_side(s14_ctx_reg),
        .out_valid(d5_valid), .quot(d5_quot), .out_side(d5_ctx)
    );

    // ---------------- outputs ----------------
    assign done            = done_reg;
    assign new_pos_ax      = out_bod_reg.ax;
    assign new_pos_ay      = out_bod_reg.ay;
    assign new_vel_ax      = out_bod_reg.vax;
    assign new_vel_ay      = out_bod_reg.vay;
    assign new_pos_bx      = out_bod_reg.bx;
    assign new_pos_by      = out_bod_reg.by;
    assign new_vel_bx      = out_bod_reg.vbx;
    assign new_vel_by      = out_bod_reg.vby;
    assign in_contact      = out_contact_reg;
    assign impulse_applied = out_applied_reg;

    `ASSERT_NEVER(a_impulse_needs_contact, done && impulse_applied && !in_contact, "impulse without contact")
    `ASSERT_IMPLY(a_kick_needs_push_stage, d5_valid, d5_ctx.contact || !d5_ctx.imp_ok, "impulse flagged outside contact")

endmodule
